// ===== sv/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } in_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StPad,
    StRound,
    StAdd,
    StEmit
  } core_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sha_fifo.sv =====
`default_nettype none
module sha_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire sha_pkg::in_item_t wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output sha_pkg::in_item_t     rd_data_o
);
  sha_pkg::in_item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ===== sv/sha_core.sv =====
`default_nettype none
module sha_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sha_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            out_word_o,
  output logic [2:0]             out_index_o
);
  sha_pkg::core_state_e st_q, st_d;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [3:0]  pos_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  // pad_q: padding phase active; mark_q: 0x80 still owed; fin_q: length words pushed
  logic        pad_q, mark_q, fin_q, len_hi_q;
  logic [31:0] push_w;
  logic        push_en;

  logic [2:0]  cnt;
  logic [31:0] keep, msk;
  logic [31:0] x15, x2, g0, g1, wn, wt, s1, ch, t1, s0, mj;

  assign cnt  = (!in_data_i.last || in_data_i.count > 3'd4) ? 3'd4 : in_data_i.count;
  assign keep = (cnt == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {cnt, 3'b000}));
  assign msk  = (cnt == 3'd4) ? 32'h0 : (32'h80000000 >> {cnt, 3'b000});

  assign x15 = w_q[4'(rnd_q + 6'd1)];
  assign x2  = w_q[4'(rnd_q + 6'd14)];
  assign g0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
  assign g1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
  assign wn  = w_q[rnd_q[3:0]] + g0 + w_q[4'(rnd_q + 6'd9)] + g1;
  assign wt  = (rnd_q >= 6'd16) ? wn : w_q[rnd_q[3:0]];
  assign s1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
             ^ {v_q[4][24:0], v_q[4][31:25]};
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + s1 + ch + sha_pkg::round_k(rnd_q) + wt;
  assign s0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
             ^ {v_q[0][21:0], v_q[0][31:22]};
  assign mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

  // padding word source
  always_comb begin
    priority if (mark_q)               push_w = 32'h80000000;
    else if (pos_q == 4'd14 && !fin_q) push_w = len_q[63:32];
    else if (len_hi_q)                 push_w = len_q[31:0];
    else                               push_w = 32'h0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sha_pkg::StIdle:  if (in_valid_i) st_d = (pos_q == 4'd15 || in_data_i.last)
                                              ? sha_pkg::StLoad : sha_pkg::StIdle;
      sha_pkg::StLoad:  st_d = (pos_q == 4'd0) ? sha_pkg::StRound
                             : (pad_q ? sha_pkg::StPad : sha_pkg::StIdle);
      sha_pkg::StPad:   st_d = (pos_q == 4'd15) ? sha_pkg::StLoad : sha_pkg::StPad;
      sha_pkg::StRound: st_d = (rnd_q == 6'd63) ? sha_pkg::StAdd : sha_pkg::StRound;
      sha_pkg::StAdd:   st_d = (pad_q && fin_q) ? sha_pkg::StEmit
                             : (pad_q ? sha_pkg::StPad : sha_pkg::StIdle);
      sha_pkg::StEmit:  st_d = (out_ready_i && idx_q == 3'd7) ? sha_pkg::StIdle
                                                              : sha_pkg::StEmit;
      default:          st_d = sha_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = (st_q == sha_pkg::StIdle);
    out_valid_o = (st_q == sha_pkg::StEmit);
    out_word_o  = h_q[idx_q];
    out_index_o = idx_q;
    push_en     = (st_q == sha_pkg::StPad);
  end

  // StLoad only re-dispatches; the word itself is written on accept
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      w_q[pos_q] <= (in_data_i.word & keep) | msk;
    end else if (push_en) begin
      w_q[pos_q] <= push_w;
    end else if (st_q == sha_pkg::StRound && rnd_q >= 6'd16) begin
      w_q[rnd_q[3:0]] <= wn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sha_pkg::StIdle;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::init_h(3'(i));
        v_q[i] <= 32'h0;
      end
      pos_q <= 4'd0; len_q <= 64'd0; rnd_q <= 6'd0; idx_q <= 3'd0;
      pad_q <= 1'b0; mark_q <= 1'b0; fin_q <= 1'b0; len_hi_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        sha_pkg::StIdle: if (in_valid_i) begin
          pos_q  <= pos_q + 4'd1;
          len_q  <= len_q + {58'd0, cnt, 3'b000};
          pad_q  <= in_data_i.last;
          mark_q <= in_data_i.last && (cnt == 3'd4);
        end
        sha_pkg::StLoad: begin
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= 6'd0;
        end
        sha_pkg::StPad: begin
          pos_q  <= pos_q + 4'd1;
          mark_q <= 1'b0;
          if (!mark_q && pos_q == 4'd14) begin fin_q <= 1'b1; len_hi_q <= 1'b1; end
          if (!mark_q && pos_q == 4'd15) len_hi_q <= 1'b0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= 6'd0;
        end
        sha_pkg::StRound: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + s0 + mj;
          rnd_q  <= rnd_q + 6'd1;
        end
        sha_pkg::StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          idx_q <= 3'd0;
        end
        sha_pkg::StEmit: if (out_ready_i) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
            pos_q <= 4'd0; len_q <= 64'd0;
            pad_q <= 1'b0; fin_q <= 1'b0; len_hi_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/sha256_message_digest.sv =====
// SHA-256 over a stream of big-endian 32-bit message words; the last word carries
// its count of valid leading bytes. Padding and the 64-bit length are added inside,
// then the eight digest words come out, index 0 first, tlast on the eighth. A two
// word queue sits ahead of the compression engine. Words are loaded while the core is
// idle; every 16th word triggers a block compression (64 rounds, one reload, one add) on the
// single shared round unit; the last word adds a dispatch state unless it closes a block,
// then come the padding words, one or two block compressions and eight digest words.
`default_nettype none
module sha256_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // message_word[31:0], byte_count[34:32]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // digest_word[31:0], word_index[34:32]
  output logic             m_axis_tlast
);
  sha_pkg::in_item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [31:0] dw;
  logic [2:0]  di;

  assign in_item = '{word: s_axis_tdata[31:0], count: s_axis_tdata[34:32],
                     last: s_axis_tlast};

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready), .wr_data_i(in_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(dw), .out_index_o(di)
  );

  assign m_axis_tdata = {5'd0, di, dw};
  assign m_axis_tlast = (di == 3'd7);
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } msg_word_t;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_message_digest dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  msg_word_t    pending_words[$];
  digest_word_t digest_fifo[$];
  int unsigned  mismatches = 0;
  int unsigned  digests_seen = 0;
  int unsigned  words_sent = 0;
  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;
  bit           hold_send = 1'b0;

  // predictor state
  logic [31:0] hash_h [8];
  logic [31:0] sched [16];
  logic [3:0]  slot;
  logic [63:0] msg_bits;

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic compress();
    logic [31:0] v [8];
    logic [31:0] x15, x2, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x15 = sched[(t - 15) & 15];
        x2  = sched[(t - 2) & 15];
        sched[t & 15] = sched[t & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
                        + sched[(t - 7) & 15] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + sched[t & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic load_word(input logic [31:0] w);
    sched[slot] = w;
    slot = slot + 4'd1;
    if (slot == 4'd0) compress();
  endtask

  task automatic predict_digest(input msg_word_t m);
    int unsigned n;
    logic [31:0] keep;
    digest_word_t d;
    if (!m.last) begin
      msg_bits = msg_bits + 64'd32;
      load_word(m.word);
      return;
    end
    n = (m.count > 3'd4) ? 4 : m.count;
    msg_bits = msg_bits + 64'(8 * n);
    if (n == 4) begin
      load_word(m.word);
      load_word(32'h80000000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
      load_word((m.word & keep) | (32'h80000000 >> (8 * n)));
    end
    while (slot != 4'd14) load_word(32'h0);
    load_word(msg_bits[63:32]);
    load_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.digest = hash_h[i];
      d.index  = 3'(i);
      d.last   = (i == 7);
      digest_fifo.push_back(d);
    end
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    slot = '0;
    msg_bits = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("digest word %0d: %s got %h want %h", digests_seen, what, got, want);
    mismatches++;
  endtask

  task automatic queue_word(input logic [31:0] w, input logic [2:0] c, input logic l);
    msg_word_t m;
    m.word = w; m.count = c; m.last = l;
    pending_words.push_back(m);
  endtask

  task automatic queue_message(input int unsigned full_words, input logic [2:0] c);
    for (int i = 0; i < full_words; i++) queue_word($urandom, 3'($urandom), 1'b0);
    queue_word($urandom, c, 1'b1);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      words_sent++;
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (rst_ni && !hold_send && pending_words.size() > 0
          && $urandom_range(99, 0) >= send_idle) begin
        msg_word_t m;
        m = pending_words.pop_front();
        predict_digest(m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, m.count, m.word};
        s_axis_tlast  <= m.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99, 0) >= recv_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (digest_fifo.size() == 0) begin
        report_mismatch("unexpected", m_axis_tdata[31:0], 32'h0);
      end else begin
        digest_word_t d;
        d = digest_fifo.pop_front();
        if (m_axis_tdata[31:0] !== d.digest)
          report_mismatch("digest", m_axis_tdata[31:0], d.digest);
        if (m_axis_tdata[34:32] !== d.index)
          report_mismatch("index", 32'(m_axis_tdata[34:32]), 32'(d.index));
        if (m_axis_tlast !== d.last)
          report_mismatch("tlast", 32'(m_axis_tlast), 32'(d.last));
      end
      digests_seen++;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || digest_fifo.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned msg_len;
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    for (int i = 0; i < 16; i++) sched[i] = '0;
    slot = '0;
    msg_bits = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty message, short tails, extremes, tail over 55 bytes
    queue_word(32'hffffffff, 3'd0, 1'b1);
    queue_word(32'h61626300, 3'd3, 1'b1);
    queue_word(32'hffffffff, 3'd1, 1'b1);
    queue_word(32'hffffffff, 3'd2, 1'b1);
    queue_word(32'h00000000, 3'd4, 1'b1);
    queue_word(32'hffffffff, 3'd7, 1'b1);
    queue_word(32'hffffffff, 3'd5, 1'b0);
    queue_word(32'h12345678, 3'd6, 1'b1);
    queue_message(13, 3'd4);
    send_idle = 16; recv_idle = 45;
    drain();

    // sender has stayed idle until all digests are back; now two long tails
    hold_send = 1'b1;
    queue_message(14, 3'd3);
    queue_message(15, 3'd4);
    hold_send = 1'b0;
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 16 : (phase == 1) ? 45 : 0;
      recv_idle = (phase == 0) ? 45 : (phase == 1) ? 16 : 0;
      for (int k = 0; k < 9; k++) begin
        msg_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 16) : $urandom_range(17, 0);
        queue_message(msg_len, 3'($urandom));
      end
      drain();
      hold_send = 1'b1;
      repeat (20) @(posedge clk_i);
      hold_send = 1'b0;
    end
    drain();
    repeat (300) @(posedge clk_i);

    $display("sent %0d message words, checked %0d digest words", words_sent, digests_seen);
    $display("covered empty, partial, full and block-crossing tails under back-pressure");
    if (mismatches == 0 && digest_fifo.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
